/* src/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, command and operation codes, and the queue entry type.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + 1);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] NEWLINE    = 8'd10;

	localparam logic [2:0] CMD_PUT       = 3'd0;
	localparam logic [2:0] CMD_BACKSPACE = 3'd1;
	localparam logic [2:0] CMD_CLEAR     = 3'd2;
	localparam logic [2:0] CMD_GOTO      = 3'd3;
	localparam logic [2:0] CMD_SAVE      = 3'd4;
	localparam logic [2:0] CMD_RESTORE   = 3'd5;
	localparam logic [2:0] CMD_READ      = 3'd6;

	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_PUT_CHAR  = 4'd1;
	localparam logic [3:0] OP_NEWLINE   = 4'd2;
	localparam logic [3:0] OP_BACKSPACE = 4'd3;
	localparam logic [3:0] OP_CLEAR     = 4'd4;
	localparam logic [3:0] OP_GOTO      = 4'd5;
	localparam logic [3:0] OP_SAVE      = 4'd6;
	localparam logic [3:0] OP_RESTORE   = 4'd7;
	localparam logic [3:0] OP_READ      = 4'd8;

	typedef struct packed {
		logic [3:0]        op;
		logic [7:0]        char_code;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] addr;
	} tcw_item_t;

endpackage

/* src/tcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts commands, decodes them into operations and clamps the goto row.
// ----------------------------------------------------------------------------
module tcw_front
	import tcw_pkg::*;
(
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  command,
	input  logic [7:0]  char_code,
	input  logic [4:0]  row,
	input  logic [10:0] read_address,
	output logic        push,
	output tcw_item_t   item
);

	assign push = start && !busy;

	always_comb begin
		item.op        = OP_NOP;
		item.char_code = char_code;
		item.addr      = ADDR_W'(read_address);
		if (int'(row) >= ROWS) begin
			item.row = ROW_W'(ROWS);
		end else begin
			item.row = ROW_W'(row);
		end
		unique case (command)
			CMD_PUT: begin
				item.op = (char_code == NEWLINE) ? OP_NEWLINE : OP_PUT_CHAR;
			end
			CMD_BACKSPACE: item.op = OP_BACKSPACE;
			CMD_CLEAR:     item.op = OP_CLEAR;
			CMD_GOTO:      item.op = OP_GOTO;
			CMD_SAVE:      item.op = OP_SAVE;
			CMD_RESTORE:   item.op = OP_RESTORE;
			CMD_READ: begin
				item.op = (int'(read_address) < CELLS) ? OP_READ : OP_NOP;
			end
			default:       item.op = OP_NOP;
		endcase
	end

endmodule

/* src/tcw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
module tcw_queue
	import tcw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tcw_item_t push_item,
	input  logic      pop,
	output tcw_item_t head,
	output logic      empty,
	output logic      full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tcw_item_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/tcw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer engine
// Owns the cell memory and the cursor, executes queued operations, and runs
// the reset fill, clear, and scroll sweeps.
// ----------------------------------------------------------------------------
module tcw_back
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_attribute_we,
	input  logic [7:0]  text_attribute,
	input  tcw_item_t   head,
	input  logic        empty,
	output logic        pop,
	output logic        init_busy,
	output logic        done,
	output logic [10:0] cursor_offset,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_BLANK  = 3'd5;
	localparam logic [2:0] ST_CLEAR  = 3'd6;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(CELLS - COLUMNS);

	logic [15:0]       mem [CELLS];
	logic [15:0]       rdata_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic [ADDR_W-1:0] raddr;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [7:0]        attr_q;
	logic [7:0]        char_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CUR_W-1:0]  saved_cursor_q;
	logic [ROW_W-1:0]  saved_row_q;
	logic [COL_W-1:0]  saved_col_q;
	logic              sc_v_s1;
	logic [ADDR_W-1:0] sc_wa_s1;
	logic              done_q;
	logic [7:0]        rc_q;
	logic [7:0]        ra_q;

	logic              past_end;
	logic [CUR_W-1:0]  cursor_dec;

	assign pop           = (state_q == ST_IDLE) && !empty;
	assign init_busy     = (state_q == ST_INIT);
	assign done          = done_q;
	assign cursor_offset = 11'(cursor_q);
	assign read_char     = rc_q;
	assign read_attr     = ra_q;

	assign past_end   = (row_q == ROW_W'(ROWS));
	assign cursor_dec = cursor_q - 1'b1;
	assign raddr      = (state_q == ST_SCROLL) ? ptr_q : head.addr;

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = {BLANK_CHAR, attr_q};
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = {BLANK_CHAR, RESET_ATTR};
			end
			ST_CLEAR: we = 1'b1;
			ST_SCROLL, ST_DRAIN: begin
				we    = sc_v_s1;
				waddr = sc_wa_s1;
				wdata = rdata_q;
			end
			ST_BLANK: begin
				we = 1'b1;
				if (ptr_q == LAST_ROW) begin
					wdata = {char_q, attr_q};
				end
			end
			ST_IDLE: begin
				if (pop && head.op == OP_PUT_CHAR && !past_end) begin
					we    = 1'b1;
					waddr = ADDR_W'(cursor_q);
					wdata = {head.char_code, attr_q};
				end else if (pop && head.op == OP_BACKSPACE && cursor_q != '0) begin
					we    = 1'b1;
					waddr = ADDR_W'(cursor_dec);
				end
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		sc_wa_s1 <= ptr_q - ADDR_W'(COLUMNS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			ptr_q          <= '0;
			attr_q         <= RESET_ATTR;
			char_q         <= '0;
			cursor_q       <= '0;
			row_q          <= '0;
			col_q          <= '0;
			saved_cursor_q <= '0;
			saved_row_q    <= '0;
			saved_col_q    <= '0;
			sc_v_s1        <= 1'b0;
			done_q         <= 1'b0;
			rc_q           <= '0;
			ra_q           <= '0;
		end else begin
			done_q  <= 1'b0;
			sc_v_s1 <= (state_q == ST_SCROLL);
			if (text_attribute_we) begin
				attr_q <= text_attribute;
			end
			unique case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_SCROLL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					ptr_q   <= LAST_ROW;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_ADDR) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						cursor_q <= CUR_W'(CELLS - COLUMNS + 1);
						row_q    <= ROW_W'(ROWS - 1);
						col_q    <= COL_W'(1);
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					rc_q    <= rdata_q[15:8];
					ra_q    <= rdata_q[7:0];
				end
				ST_IDLE: begin
					if (pop) begin
						rc_q   <= '0;
						ra_q   <= '0;
						done_q <= 1'b1;
						case (head.op)
							OP_PUT_CHAR: begin
								if (past_end) begin
									done_q  <= 1'b0;
									char_q  <= head.char_code;
									ptr_q   <= ADDR_W'(COLUMNS);
									state_q <= ST_SCROLL;
								end else begin
									cursor_q <= cursor_q + 1'b1;
									if (int'(col_q) == COLUMNS - 1) begin
										col_q <= '0;
										row_q <= row_q + 1'b1;
									end else begin
										col_q <= col_q + 1'b1;
									end
								end
							end
							OP_NEWLINE: begin
								if (!past_end) begin
									cursor_q <= cursor_q + CUR_W'(COLUMNS) - CUR_W'(col_q);
									row_q    <= row_q + 1'b1;
									col_q    <= '0;
								end
							end
							OP_BACKSPACE: begin
								if (cursor_q != '0) begin
									cursor_q <= cursor_dec;
									if (col_q == '0) begin
										col_q <= COL_W'(COLUMNS - 1);
										row_q <= row_q - 1'b1;
									end else begin
										col_q <= col_q - 1'b1;
									end
								end
							end
							OP_CLEAR: begin
								done_q   <= 1'b0;
								ptr_q    <= '0;
								cursor_q <= '0;
								row_q    <= '0;
								col_q    <= '0;
								state_q  <= ST_CLEAR;
							end
							OP_GOTO: begin
								cursor_q <= CUR_W'(int'(head.row) * COLUMNS);
								row_q    <= head.row;
								col_q    <= '0;
							end
							OP_SAVE: begin
								saved_cursor_q <= cursor_q;
								saved_row_q    <= row_q;
								saved_col_q    <= col_q;
							end
							OP_RESTORE: begin
								cursor_q <= saved_cursor_q;
								row_q    <= saved_row_q;
								col_q    <= saved_col_q;
							end
							OP_READ: begin
								done_q  <= 1'b0;
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_beat_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !done_q)
		else $error("result beat during reset fill");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cursor_q) <= CELLS)
		else $error("cursor beyond end of screen");

	a_cursor_matches_row_col: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cursor_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("cursor offset disagrees with row and column");

	a_scroll_copy_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sc_v_s1 |-> (state_q == ST_SCROLL || state_q == ST_DRAIN))
		else $error("scroll copy outside scroll sweep");
`endif

endmodule

/* src/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine with an 80 by 25 cell memory and a write cursor.
// ----------------------------------------------------------------------------
// A command is taken at a clock edge where start is high and busy is low.
// Each command gives exactly one result beat: done is high for one cycle and
// cursor_offset, read_char and read_attr are valid in that cycle. The
// receiver cannot stall; every beat must be taken when it appears.
// Commands pass through a two-entry queue, so busy rises only when the queue
// is full or the reset fill runs.
// For put without a scroll, newline, backspace, goto, save and restore, done
// rises in the cycle after the command leaves the queue; a cell read first
// passes through the read state. Simple commands leave the queue one per
// cycle while it is not empty; a read holds it in its read state. Clear
// walks all 2000 cells, one per cycle. A put while the cursor is past the end
// scrolls through the cell memory port: a row copy of 1920 cells, a drain
// state and last-row blanking. The user writes text_attribute through
// text_attribute_we only while idle; the block itself does not enforce this.
// Reset fills all 2000 cells with blanks, one per cycle, with busy held high.
// ----------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [7:0]  char_code,
	input  logic [4:0]  row,
	input  logic [10:0] read_address,
	input  logic        text_attribute_we,
	input  logic [7:0]  text_attribute,
	output logic        done,
	output logic [10:0] cursor_offset,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr
);

	logic      push;
	tcw_item_t push_item;
	tcw_item_t head;
	logic      pop;
	logic      empty;
	logic      full;
	logic      init_busy;

	assign busy = full || init_busy;

	tcw_front u_front (
		.start        (start),
		.busy         (busy),
		.command      (command),
		.char_code    (char_code),
		.row          (row),
		.read_address (read_address),
		.push         (push),
		.item         (push_item)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	tcw_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.text_attribute_we (text_attribute_we),
		.text_attribute    (text_attribute),
		.head              (head),
		.empty             (empty),
		.pop               (pop),
		.init_busy         (init_busy),
		.done              (done),
		.cursor_offset     (cursor_offset),
		.read_char         (read_char),
		.read_attr         (read_attr)
	);

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, backspace, clear, goto, save, restore and read commands, with
// attribute changes between phases, into the console engine. It checks every
// result beat against a cycle-free model of the 80 by 25 cell store and the
// cursor.
// ----------------------------------------------------------------------------
module tb;
	import tcw_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_BEATS   = 150;
	localparam int TAIL_CYCLES   = 50;

	typedef struct {
		bit          is_cfg;
		logic [7:0]  attr_value;
		logic [2:0]  command;
		logic [7:0]  char_code;
		logic [4:0]  row;
		logic [10:0] read_address;
		bit          near_cursor;
		bit          drain_first;
		int          gap;
	} console_cmd_t;

	typedef struct packed {
		logic [10:0] cursor_offset;
		logic [7:0]  read_char;
		logic [7:0]  read_attr;
	} console_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = CMD_PUT;
	logic [7:0]  char_code = 8'd0;
	logic [4:0]  row = 5'd0;
	logic [10:0] read_address = 11'd0;
	logic        text_attribute_we = 1'b0;
	logic [7:0]  text_attribute = RESET_ATTR;
	logic        done;
	logic [10:0] cursor_offset;
	logic [7:0]  read_char;
	logic [7:0]  read_attr;

	logic [7:0] screen_char [CELLS];
	logic [7:0] screen_attr [CELLS];
	int         cur_pos;
	int         saved_pos;
	logic [7:0] attr_reg;

	console_cmd_t  command_backlog [$];
	console_view_t expected_views [$];
	int issued_beats = 0;
	int retired_beats = 0;
	int error_count = 0;
	int scroll_count = 0;
	int clear_count = 0;
	int read_count = 0;
	int attr_writes = 0;

	text_console_writer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.command           (command),
		.char_code         (char_code),
		.row               (row),
		.read_address      (read_address),
		.text_attribute_we (text_attribute_we),
		.text_attribute    (text_attribute),
		.done              (done),
		.cursor_offset     (cursor_offset),
		.read_char         (read_char),
		.read_attr         (read_attr)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#40_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic console_view_t apply_console_command(input logic [2:0] cmd,
			input logic [7:0] code, input logic [4:0] target_row, input logic [10:0] addr);
		console_view_t view;
		int target;
		view = '0;
		case (cmd)
			CMD_PUT: begin
				if (code == NEWLINE) begin
					target = (cur_pos / COLUMNS + 1) * COLUMNS;
					cur_pos = (target > CELLS) ? CELLS : target;
				end else begin
					if (cur_pos >= CELLS) begin
						for (int i = COLUMNS; i < CELLS; i++) begin
							screen_char[i - COLUMNS] = screen_char[i];
							screen_attr[i - COLUMNS] = screen_attr[i];
						end
						for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
							screen_char[i] = BLANK_CHAR;
							screen_attr[i] = attr_reg;
						end
						cur_pos = CELLS - COLUMNS;
						scroll_count++;
					end
					screen_char[cur_pos] = code;
					screen_attr[cur_pos] = attr_reg;
					cur_pos++;
				end
			end
			CMD_BACKSPACE: begin
				if (cur_pos > 0) begin
					cur_pos--;
					if (cur_pos < CELLS) begin
						screen_char[cur_pos] = BLANK_CHAR;
						screen_attr[cur_pos] = attr_reg;
					end
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen_char[i] = BLANK_CHAR;
					screen_attr[i] = attr_reg;
				end
				cur_pos = 0;
				clear_count++;
			end
			CMD_GOTO: begin
				target = int'(target_row) * COLUMNS;
				cur_pos = (target > CELLS) ? CELLS : target;
			end
			CMD_SAVE: saved_pos = cur_pos;
			CMD_RESTORE: cur_pos = saved_pos;
			CMD_READ: begin
				read_count++;
				if (int'(addr) < CELLS) begin
					view.read_char = screen_char[addr];
					view.read_attr = screen_attr[addr];
				end
			end
			default: ;
		endcase
		view.cursor_offset = cur_pos[10:0];
		return view;
	endfunction

	function automatic console_cmd_t console_cmd(input logic [2:0] cmd, input logic [7:0] code,
			input logic [4:0] target_row, input logic [10:0] addr);
		console_cmd_t c;
		c.is_cfg = 1'b0;
		c.attr_value = 8'd0;
		c.command = cmd;
		c.char_code = code;
		c.row = target_row;
		c.read_address = addr;
		c.near_cursor = 1'b0;
		c.drain_first = 1'b0;
		c.gap = $urandom_range(0, 16);
		return c;
	endfunction

	function automatic console_cmd_t attr_write(input logic [7:0] value);
		console_cmd_t c;
		c = console_cmd(CMD_PUT, 8'd0, 5'd0, 11'd0);
		c.is_cfg = 1'b1;
		c.attr_value = value;
		c.gap = 0;
		return c;
	endfunction

	function automatic console_cmd_t random_console_cmd();
		console_cmd_t c;
		int pick;
		c = console_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
			11'($urandom_range(0, 2047)));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			c.command = CMD_PUT;
			if ($urandom_range(0, 9) == 0)
				c.char_code = NEWLINE;
		end else if (pick < 55)
			c.command = CMD_BACKSPACE;
		else if (pick < 57)
			c.command = CMD_CLEAR;
		else if (pick < 69)
			c.command = CMD_GOTO;
		else if (pick < 75)
			c.command = CMD_SAVE;
		else if (pick < 81)
			c.command = CMD_RESTORE;
		else if (pick < 98) begin
			c.command = CMD_READ;
			c.near_cursor = 1'($urandom_range(0, 1));
		end else
			c.command = CMD_UNUSED;
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		logic launch;
		logic cfg_write;
		logic gap_loaded;
		int gap_left;
		int addr_pick;
		console_cmd_t next_cmd;
		if (!arst_n) begin
			start <= 1'b0;
			command <= CMD_PUT;
			char_code <= 8'd0;
			row <= 5'd0;
			read_address <= 11'd0;
			text_attribute_we <= 1'b0;
			text_attribute <= RESET_ATTR;
			gap_loaded = 1'b0;
			gap_left = 0;
		end else begin
			launch = 1'b0;
			cfg_write = 1'b0;
			if (start && busy)
				launch = 1'b1;
			else begin
				if (start) begin
					expected_views.push_back(apply_console_command(command, char_code, row,
						read_address));
					issued_beats++;
				end
				if (command_backlog.size() != 0) begin
					if (!gap_loaded) begin
						gap_left = command_backlog[0].gap;
						gap_loaded = 1'b1;
					end
					if (gap_left != 0)
						gap_left--;
					else if (command_backlog[0].is_cfg) begin
						if (issued_beats == retired_beats && !busy) begin
							next_cmd = command_backlog.pop_front();
							gap_loaded = 1'b0;
							cfg_write = 1'b1;
							text_attribute <= next_cmd.attr_value;
							attr_reg = next_cmd.attr_value;
							attr_writes++;
						end
					end else if (!command_backlog[0].drain_first
							|| issued_beats == retired_beats) begin
						next_cmd = command_backlog.pop_front();
						gap_loaded = 1'b0;
						launch = 1'b1;
						addr_pick = int'(next_cmd.read_address);
						if (next_cmd.near_cursor) begin
							addr_pick = cur_pos - int'($urandom_range(1, 120));
							if (addr_pick < 0)
								addr_pick = $urandom_range(0, CELLS - 1);
						end
						command <= next_cmd.command;
						char_code <= next_cmd.char_code;
						row <= next_cmd.row;
						read_address <= addr_pick[10:0];
					end
				end
			end
			start <= launch;
			text_attribute_we <= cfg_write;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		console_view_t want;
		if (!arst_n)
			retired_beats <= 0;
		else if (done) begin
			if (expected_views.size() == 0) begin
				$error("result beat with no command outstanding");
				error_count++;
			end else begin
				want = expected_views.pop_front();
				if (cursor_offset !== want.cursor_offset) begin
					$error("cursor_offset: expected %0d, got %0d", want.cursor_offset,
						cursor_offset);
					error_count++;
				end
				if (read_char !== want.read_char) begin
					$error("read_char: expected 0x%02h, got 0x%02h", want.read_char, read_char);
					error_count++;
				end
				if (read_attr !== want.read_attr) begin
					$error("read_attr: expected 0x%02h, got 0x%02h", want.read_attr, read_attr);
					error_count++;
				end
			end
			retired_beats <= retired_beats + 1;
		end
	end

	initial begin : stimulus
		console_cmd_t c;
		int burst_left;
		for (int i = 0; i < CELLS; i++) begin
			screen_char[i] = BLANK_CHAR;
			screen_attr[i] = RESET_ATTR;
		end
		cur_pos = 0;
		saved_pos = 0;
		attr_reg = RESET_ATTR;

		command_backlog.push_back(console_cmd(CMD_READ, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, 8'h41, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, 8'hFF, 5'd31, 11'd2047));
		command_backlog.push_back(console_cmd(CMD_PUT, 8'h00, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_READ, 8'hFF, 5'd31, 11'd1));
		command_backlog.push_back(console_cmd(CMD_BACKSPACE, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, NEWLINE, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_SAVE, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_GOTO, 8'd0, 5'd24, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, 8'h7E, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, NEWLINE, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, NEWLINE, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_PUT, 8'h5A, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_READ, 8'd0, 5'd0, 11'd1920));
		command_backlog.push_back(console_cmd(CMD_READ, 8'd0, 5'd0, 11'd2047));
		command_backlog.push_back(console_cmd(CMD_READ, 8'd0, 5'd0, 11'd1999));
		command_backlog.push_back(console_cmd(CMD_GOTO, 8'd0, 5'd31, 11'd0));
		command_backlog.push_back(console_cmd(CMD_BACKSPACE, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_RESTORE, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_UNUSED, 8'hFF, 5'd31, 11'd2047));
		command_backlog.push_back(console_cmd(CMD_GOTO, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_BACKSPACE, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(attr_write(8'hFF));
		command_backlog.push_back(console_cmd(CMD_CLEAR, 8'd0, 5'd0, 11'd0));
		command_backlog.push_back(console_cmd(CMD_READ, 8'd0, 5'd0, 11'd0));

		burst_left = 0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				command_backlog.push_back(attr_write(8'h00));
			else if (phase == 1)
				command_backlog.push_back(attr_write(8'hFF));
			else
				command_backlog.push_back(attr_write(8'($urandom_range(0, 255))));
			for (int n = 0; n < PHASE_BEATS; n++) begin
				c = random_console_cmd();
				if (burst_left == 0 && $urandom_range(0, 9) == 0)
					burst_left = $urandom_range(5, 30);
				if (burst_left != 0) begin
					c.gap = 0;
					burst_left--;
				end
				c.drain_first = (n == 0) || ($urandom_range(0, 99) == 0);
				command_backlog.push_back(c);
			end
		end

		while (command_backlog.size() != 0 || start || issued_beats != retired_beats)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_views.size() != 0) begin
			$error("%0d result beats never arrived", expected_views.size());
			error_count++;
		end
		$display("Ran %0d commands under %0d attribute settings.", issued_beats,
			attr_writes + 1);
		$display("Saw %0d scrolls, %0d clears and %0d cell reads.", scroll_count,
			clear_count, read_count);
		if (error_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
sim/tb.sv
